// File: hdl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants and types for the 3x3 median grid filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int MF3_MAX_WIDTH    = 1024;
    localparam int MF3_SAMPLE_BITS  = 32;

    localparam int GRID_WIDTH_BITS  = 11;
    localparam int GRID_HEIGHT_BITS = 13;
    localparam int CFG_DATA_BITS    = 13;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int ROW_BITS         = 12;
    localparam int COL_OUT_BITS     = 10;
    localparam int HEIGHT_LIMIT     = 4096;
    localparam int RESET_GRID_DIM   = 3;

    // median pipe: column sort (3) + window reduce (6)
    localparam int MED_LATENCY      = 9;
    localparam int FIFO_DEPTH       = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_HEIGHT = CFG_INDEX_BITS'(1);

    // per-sample bookkeeping carried alongside the median pipe
    typedef struct packed {
        logic [ROW_BITS-1:0]     row;
        logic [COL_OUT_BITS-1:0] col;
        logic                    med;     // a window completes on this sample
        logic                    border;  // sample is a border cell
    } mf3_meta_t;

endpackage

// File: hdl/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median
// Pipelined 3x3 median: sorts each incoming column, keeps the last three
// sorted columns, and reduces them one compare level per stage.
// ----------------------------------------------------------------------------
module mf3_median #(
    parameter int SAMPLE_BITS = mf3_pkg::MF3_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          col_valid,
    input  logic signed [SAMPLE_BITS-1:0] col_top,
    input  logic signed [SAMPLE_BITS-1:0] col_mid,
    input  logic signed [SAMPLE_BITS-1:0] col_bot,
    output logic                          med_valid,
    output logic signed [SAMPLE_BITS-1:0] med_value
);

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;

    function automatic smp_t smin(input smp_t a, input smp_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic smp_t smax(input smp_t a, input smp_t b);
        return (a < b) ? b : a;
    endfunction

    logic [8:0] vld_reg;

    // column sort
    smp_t s1_lo_reg, s1_hi_reg, s1_c_reg;
    smp_t s2_lo_reg, s2_mid_reg, s2_hi_reg;

    // sorted window columns, index 0 is the oldest
    smp_t win_lo_reg [3];
    smp_t win_me_reg [3];
    smp_t win_hi_reg [3];

    // window reduction
    smp_t s4_m1_reg, s4_l2_reg, s4_n1_reg, s4_h2_reg, s4_p_reg, s4_q_reg, s4_e2_reg;
    smp_t s5_maxlo_reg, s5_minhi_reg, s5_t_reg, s5_p_reg;
    smp_t s6_a_reg, s6_b_reg, s6_c_reg;
    smp_t s7_lo_reg, s7_hi_reg, s7_c_reg;
    smp_t s8_lo_reg, s8_t_reg;
    smp_t s9_med_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[7:0], col_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                win_lo_reg[i] <= '0;
                win_me_reg[i] <= '0;
                win_hi_reg[i] <= '0;
            end
        end else if (vld_reg[1]) begin
            win_lo_reg[0] <= win_lo_reg[1];
            win_me_reg[0] <= win_me_reg[1];
            win_hi_reg[0] <= win_hi_reg[1];
            win_lo_reg[1] <= win_lo_reg[2];
            win_me_reg[1] <= win_me_reg[2];
            win_hi_reg[1] <= win_hi_reg[2];
            win_lo_reg[2] <= smin(s2_lo_reg, s2_mid_reg);
            win_me_reg[2] <= smax(s2_lo_reg, s2_mid_reg);
            win_hi_reg[2] <= s2_hi_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_lo_reg    <= smin(col_top, col_mid);
        s1_hi_reg    <= smax(col_top, col_mid);
        s1_c_reg     <= col_bot;

        s2_lo_reg    <= s1_lo_reg;
        s2_mid_reg   <= smin(s1_hi_reg, s1_c_reg);
        s2_hi_reg    <= smax(s1_hi_reg, s1_c_reg);

        // max of lows, min of highs, median of mids
        s4_m1_reg    <= smax(win_lo_reg[0], win_lo_reg[1]);
        s4_l2_reg    <= win_lo_reg[2];
        s4_n1_reg    <= smin(win_hi_reg[0], win_hi_reg[1]);
        s4_h2_reg    <= win_hi_reg[2];
        s4_p_reg     <= smin(win_me_reg[0], win_me_reg[1]);
        s4_q_reg     <= smax(win_me_reg[0], win_me_reg[1]);
        s4_e2_reg    <= win_me_reg[2];

        s5_maxlo_reg <= smax(s4_m1_reg, s4_l2_reg);
        s5_minhi_reg <= smin(s4_n1_reg, s4_h2_reg);
        s5_t_reg     <= smin(s4_q_reg, s4_e2_reg);
        s5_p_reg     <= s4_p_reg;

        s6_a_reg     <= s5_maxlo_reg;
        s6_b_reg     <= smax(s5_p_reg, s5_t_reg);
        s6_c_reg     <= s5_minhi_reg;

        // median of the three partial results
        s7_lo_reg    <= smin(s6_a_reg, s6_b_reg);
        s7_hi_reg    <= smax(s6_a_reg, s6_b_reg);
        s7_c_reg     <= s6_c_reg;

        s8_lo_reg    <= s7_lo_reg;
        s8_t_reg     <= smin(s7_hi_reg, s7_c_reg);

        s9_med_reg   <= smax(s8_lo_reg, s8_t_reg);
    end

    assign med_valid = vld_reg[8];
    assign med_value = s9_med_reg;

endmodule

// File: hdl/median3x3_grid_filter.sv
// ----------------------------------------------------------------------------
// median3x3_grid_filter
// Streaming 3x3 median filter over a raster height grid (signed Q16.16).
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one height sample per beat, raster order. Border cells
//   (first/last row or column) come back unchanged; each interior cell
//   comes back as the median of its 3x3 neighbourhood once its lower-right
//   neighbour has arrived. When one sample yields both, the median beat goes
//   first and tlast marks the final beat that sample caused.
//   m_ channel: value, row and column per beat.
//   cfg port: grid_width (index 0) and grid_height (index 1); any write to
//   them restarts the grid at row 0, column 0. Write only while idle.
// Path: a sample passes stage a, the median pipe, the result queue and the output register.
// Throughput: one sample per cycle while s_tready is high; the line-store memories are read once
//   and written once per sample. A sample with two results needs two output
//   beats, so the output port sets the sustained rate in that case.
// Stalls: results wait in a 16-entry queue; s_tready falls when queued
//   entries plus samples still in the pipe would fill it.
// Reset: row/col counters cleared, width and height set to 3. The line
//   stores are not cleared; no output reads an entry not yet written.
// ----------------------------------------------------------------------------
module median3x3_grid_filter #(
    parameter int MAX_WIDTH   = mf3_pkg::MF3_MAX_WIDTH,
    parameter int SAMPLE_BITS = mf3_pkg::MF3_SAMPLE_BITS
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,

    // tdata: [SAMPLE_BITS-1:0] height_in
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,

    // tdata: filtered_value, out_row (12), out_col (10), from bit 0 up
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [((SAMPLE_BITS + 29) / 8) * 8 - 1:0] m_tdata,
    output logic                                     m_tlast,

    input  logic                                     cfg_we,
    input  logic [mf3_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [mf3_pkg::CFG_DATA_BITS-1:0]        cfg_wdata
);

    import mf3_pkg::*;

    localparam int CB  = $clog2(MAX_WIDTH);
    localparam int FB  = $clog2(FIFO_DEPTH);
    localparam int OTW = ((SAMPLE_BITS + 29) / 8) * 8;

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;

    // ---------------- configuration / grid position ----------------
    logic [CB-1:0]       w_last_reg, w_last_next;
    logic [ROW_BITS-1:0] h_last_reg, h_last_next;
    logic [CB-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic                cfg_hit;
    logic [31:0]         cfg_val;

    logic s_accept;
    assign s_accept = s_tvalid && s_tready;

    // effective dimension minus one: zero maps to 1, oversize saturates
    always_comb begin
        cfg_hit     = 1'b0;
        cfg_val     = 32'(cfg_wdata);
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_GRID_WIDTH: begin
                    cfg_hit = 1'b1;
                    cfg_val = 32'(cfg_wdata[GRID_WIDTH_BITS-1:0]);
                    if (cfg_val == 32'd0) begin
                        w_last_next = '0;
                    end else if (cfg_val > 32'(MAX_WIDTH)) begin
                        w_last_next = CB'(MAX_WIDTH - 1);
                    end else begin
                        w_last_next = CB'(cfg_val - 32'd1);
                    end
                end
                CFG_GRID_HEIGHT: begin
                    cfg_hit = 1'b1;
                    cfg_val = 32'(cfg_wdata[GRID_HEIGHT_BITS-1:0]);
                    if (cfg_val == 32'd0) begin
                        h_last_next = '0;
                    end else if (cfg_val > 32'(HEIGHT_LIMIT)) begin
                        h_last_next = ROW_BITS'(HEIGHT_LIMIT - 1);
                    end else begin
                        h_last_next = ROW_BITS'(cfg_val - 32'd1);
                    end
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (s_accept) begin
            if (col_reg == w_last_reg) begin
                col_next = '0;
                row_next = (row_reg == h_last_reg) ? '0 : row_reg + ROW_BITS'(1);
            end else begin
                col_next = col_reg + CB'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg <= CB'(RESET_GRID_DIM - 1);
            h_last_reg <= ROW_BITS'(RESET_GRID_DIM - 1);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            w_last_reg <= w_last_next;
            h_last_reg <= h_last_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // ---------------- line stores ----------------
    // Read at accept, write back in the cycle after from stage a. Only a
    // one-column grid hits the same entry on back-to-back beats; that case
    // takes the forwarded values instead of the memory output.
    smp_t upper_mem  [MAX_WIDTH];
    smp_t middle_mem [MAX_WIDTH];

    smp_t      rd_up_reg, rd_mid_reg;
    logic      fwd_reg;
    smp_t      fwd_up_reg, fwd_mid_reg;

    logic      a_valid_reg;
    smp_t      a_x_reg;
    logic [CB-1:0] a_col_reg;
    mf3_meta_t a_meta_reg;
    smp_t      a_up, a_mid;

    assign a_up  = fwd_reg ? fwd_up_reg  : rd_up_reg;
    assign a_mid = fwd_reg ? fwd_mid_reg : rd_mid_reg;

    always_ff @(posedge aclk) begin
        if (a_valid_reg) begin
            upper_mem[a_col_reg]  <= a_mid;
            middle_mem[a_col_reg] <= a_x_reg;
        end
        if (s_accept) begin
            rd_up_reg  <= upper_mem[col_reg];
            rd_mid_reg <= middle_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end else begin
            a_valid_reg <= s_accept;
            if (s_accept) begin
                fwd_reg <= a_valid_reg && (a_col_reg == col_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fwd_up_reg         <= a_mid;
            fwd_mid_reg        <= a_x_reg;
            a_x_reg            <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            a_col_reg          <= col_reg;
            a_meta_reg.row     <= row_reg;
            a_meta_reg.col     <= COL_OUT_BITS'(col_reg);
            a_meta_reg.med     <= (row_reg >= ROW_BITS'(2)) && (col_reg >= CB'(2));
            a_meta_reg.border  <= (row_reg == '0) || (row_reg == h_last_reg) ||
                                  (col_reg == '0) || (col_reg == w_last_reg);
        end
    end

    // ---------------- median pipe and side band ----------------
    logic      med_valid;
    smp_t      med_value;
    mf3_meta_t meta_pipe [MED_LATENCY];
    smp_t      x_pipe    [MED_LATENCY];

    mf3_median #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .col_valid (a_valid_reg),
        .col_top   (a_up),
        .col_mid   (a_mid),
        .col_bot   (a_x_reg),
        .med_valid (med_valid),
        .med_value (med_value)
    );

    always_ff @(posedge aclk) begin
        meta_pipe[0] <= a_meta_reg;
        x_pipe[0]    <= a_x_reg;
        for (int i = 1; i < MED_LATENCY; i++) begin
            meta_pipe[i] <= meta_pipe[i-1];
            x_pipe[i]    <= x_pipe[i-1];
        end
    end

    mf3_meta_t end_meta;
    logic      push;
    assign end_meta = meta_pipe[MED_LATENCY-1];
    assign push     = med_valid && (end_meta.med || end_meta.border);

    // ---------------- result queue: one entry per sample that yields a result ----------------
    smp_t      fq_med  [FIFO_DEPTH];
    smp_t      fq_x    [FIFO_DEPTH];
    mf3_meta_t fq_meta [FIFO_DEPTH];

    logic [FB:0] wptr_reg, rptr_reg, fifo_count;
    logic [FB:0] inflight_reg, inflight_next;
    logic        fifo_empty, pop;

    assign fifo_count = wptr_reg - rptr_reg;
    assign fifo_empty = (fifo_count == '0);
    assign s_tready   = ({1'b0, fifo_count} + {1'b0, inflight_reg}) < (FB + 2)'(FIFO_DEPTH);

    always_comb begin
        inflight_next = inflight_reg;
        if (s_accept && !med_valid) begin
            inflight_next = inflight_reg + (FB + 1)'(1);
        end else if (!s_accept && med_valid) begin
            inflight_next = inflight_reg - (FB + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fq_med[wptr_reg[FB-1:0]]  <= med_value;
            fq_x[wptr_reg[FB-1:0]]    <= x_pipe[MED_LATENCY-1];
            fq_meta[wptr_reg[FB-1:0]] <= end_meta;
        end
    end

    // ---------------- output register ----------------
    logic      out_valid_reg, out_sel_reg;
    smp_t      out_med_reg, out_x_reg;
    mf3_meta_t out_meta_reg;
    logic      show_med, last_beat;

    assign show_med  = out_meta_reg.med && !out_sel_reg;
    assign last_beat = !show_med || !out_meta_reg.border;
    assign pop       = !fifo_empty && (!out_valid_reg || (m_tready && last_beat));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            inflight_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_sel_reg   <= 1'b0;
        end else begin
            inflight_reg <= inflight_next;
            if (push) begin
                wptr_reg <= wptr_reg + (FB + 1)'(1);
            end
            if (pop) begin
                rptr_reg      <= rptr_reg + (FB + 1)'(1);
                out_valid_reg <= 1'b1;
                out_sel_reg   <= 1'b0;
            end else if (out_valid_reg && m_tready) begin
                if (last_beat) begin
                    out_valid_reg <= 1'b0;
                end else begin
                    out_sel_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_med_reg  <= fq_med[rptr_reg[FB-1:0]];
            out_x_reg    <= fq_x[rptr_reg[FB-1:0]];
            out_meta_reg <= fq_meta[rptr_reg[FB-1:0]];
        end
    end

    // median beat reports the window centre, one row and column back
    smp_t                    beat_value;
    logic [ROW_BITS-1:0]     beat_row;
    logic [COL_OUT_BITS-1:0] beat_col;

    always_comb begin
        if (show_med) begin
            beat_value = out_med_reg;
            beat_row   = out_meta_reg.row - ROW_BITS'(1);
            beat_col   = out_meta_reg.col - COL_OUT_BITS'(1);
        end else begin
            beat_value = out_x_reg;
            beat_row   = out_meta_reg.row;
            beat_col   = out_meta_reg.col;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_beat;
    assign m_tdata  = OTW'({beat_col, beat_row, beat_value});

endmodule

// File: sim/mf3_result_checker.sv
// ----------------------------------------------------------------------------
// mf3_result_checker
// Watches both streams and the register port of the median grid filter,
// predicts every result beat from the accepted samples and compares them.
// ----------------------------------------------------------------------------
module mf3_result_checker (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,

    // tdata: height_in
    input  logic                                                 s_tvalid,
    input  logic                                                 s_tready,
    input  logic [((mf3_pkg::MF3_SAMPLE_BITS + 7) / 8) * 8 - 1:0]  s_tdata,

    // tdata: filtered_value, out_row, out_col, zero pad
    input  logic                                                 m_tvalid,
    input  logic                                                 m_tready,
    input  logic [((mf3_pkg::MF3_SAMPLE_BITS + 29) / 8) * 8 - 1:0] m_tdata,
    input  logic                                                 m_tlast,

    input  logic                                                 cfg_we,
    input  logic [mf3_pkg::CFG_INDEX_BITS-1:0]                   cfg_index,
    input  logic [mf3_pkg::CFG_DATA_BITS-1:0]                    cfg_wdata,

    input  logic                                                 end_of_run,
    output int                                                   mismatch_count,
    output int                                                   cells_owed
);

    import mf3_pkg::*;

    localparam int SB      = MF3_SAMPLE_BITS;
    localparam int M_BITS  = ((SB + 29) / 8) * 8;
    localparam int ROW_LSB = SB;
    localparam int COL_LSB = ROW_LSB + ROW_BITS;
    localparam int PAD_LSB = COL_LSB + COL_OUT_BITS;

    typedef struct packed {
        logic signed [SB-1:0]    value;
        logic [ROW_BITS-1:0]     row;
        logic [COL_OUT_BITS-1:0] col;
        logic                    last;
    } cell_result_t;

    cell_result_t pending_cells[$];

    // predictor state
    logic signed [SB-1:0]       upper_line  [MF3_MAX_WIDTH];
    logic signed [SB-1:0]       middle_line [MF3_MAX_WIDTH];
    logic signed [SB-1:0]       win_regs    [6];   // two older columns: up, mid, low
    logic [GRID_WIDTH_BITS-1:0]  width_reg;
    logic [GRID_HEIGHT_BITS-1:0] height_reg;
    int unsigned                 row_pos;
    int unsigned                 col_pos;
    bit                          run_closed;

    task automatic report_fail(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        $display("%0t mismatch: %s, got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic signed [SB-1:0] median_of_nine(
        input logic [8:0][SB-1:0] taps
    );
        logic signed [SB-1:0] s [9];
        logic signed [SB-1:0] t;
        int j;
        for (int i = 0; i < 9; i++) s[i] = taps[i];
        for (int i = 1; i < 9; i++) begin
            t = s[i];
            j = i - 1;
            while (j >= 0 && s[j] > t) begin
                s[j + 1] = s[j];
                j--;
            end
            s[j + 1] = t;
        end
        return s[4];
    endfunction

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MF3_MAX_WIDTH) return MF3_MAX_WIDTH;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return 32'(height_reg);
    endfunction

    task automatic filter_sample(input logic signed [SB-1:0] x);
        int unsigned w, h, r, c;
        logic signed [SB-1:0] up, mid;
        logic [8:0][SB-1:0] taps;
        cell_result_t res [2];
        int n;
        w = eff_width();
        h = eff_height();
        r = row_pos;
        c = col_pos;
        n = 0;
        if (c >= w) c = 0;
        if (r >= h) r = 0;
        up  = upper_line[c];
        mid = middle_line[c];

        // window closes on its lower-right sample: median of (r-1, c-1) first
        if (r >= 2 && c >= 2) begin
            taps = {x, mid, up, win_regs[5], win_regs[4], win_regs[3],
                    win_regs[2], win_regs[1], win_regs[0]};
            res[n].value = median_of_nine(taps);
            res[n].row   = ROW_BITS'(r - 1);
            res[n].col   = COL_OUT_BITS'(c - 1);
            res[n].last  = 1'b0;
            n++;
        end
        if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
            res[n].value = x;
            res[n].row   = ROW_BITS'(r);
            res[n].col   = COL_OUT_BITS'(c);
            res[n].last  = 1'b0;
            n++;
        end
        if (n > 0) res[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_cells = {pending_cells, res[i]};

        win_regs[0] = win_regs[3];
        win_regs[1] = win_regs[4];
        win_regs[2] = win_regs[5];
        win_regs[3] = up;
        win_regs[4] = mid;
        win_regs[5] = x;
        upper_line[c]  = mid;
        middle_line[c] = x;

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic check_beat();
        cell_result_t want;
        if (pending_cells.size() == 0) begin
            report_fail("result beat with none owed", 64'(m_tdata), '0);
        end else begin
            want = pending_cells.pop_front();
            if (m_tdata[SB-1:0] !== want.value)
                report_fail("filtered_value", 64'(m_tdata[SB-1:0]), 64'(want.value));
            if (m_tdata[ROW_LSB +: ROW_BITS] !== want.row)
                report_fail("out_row", 64'(m_tdata[ROW_LSB +: ROW_BITS]), 64'(want.row));
            if (m_tdata[COL_LSB +: COL_OUT_BITS] !== want.col)
                report_fail("out_col", 64'(m_tdata[COL_LSB +: COL_OUT_BITS]), 64'(want.col));
            if (m_tlast !== want.last)
                report_fail("tlast", 64'(m_tlast), 64'(want.last));
            if (m_tdata[M_BITS-1:PAD_LSB] !== '0)
                report_fail("tdata pad", 64'(m_tdata[M_BITS-1:PAD_LSB]), '0);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pending_cells.delete();
            for (int i = 0; i < 6; i++) win_regs[i] = '0;
            row_pos    = 0;
            col_pos    = 0;
            width_reg  = GRID_WIDTH_BITS'(RESET_GRID_DIM);
            height_reg = GRID_HEIGHT_BITS'(RESET_GRID_DIM);
            run_closed = 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_beat();
            if (cfg_we) begin
                // only the two real registers restart the grid
                if (cfg_index == CFG_GRID_WIDTH) begin
                    width_reg = cfg_wdata[GRID_WIDTH_BITS-1:0];
                    row_pos   = 0;
                    col_pos   = 0;
                end else if (cfg_index == CFG_GRID_HEIGHT) begin
                    height_reg = cfg_wdata[GRID_HEIGHT_BITS-1:0];
                    row_pos    = 0;
                    col_pos    = 0;
                end
            end
            if (s_tvalid && s_tready) filter_sample(s_tdata[SB-1:0]);
            if (end_of_run && !run_closed) begin
                run_closed = 1'b1;
                foreach (pending_cells[i])
                    report_fail("result never arrived", '1, 64'(pending_cells[i].value));
            end
        end
        cells_owed = pending_cells.size();
    end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the 3x3 median grid filter: directed corner
// cases, grids of random size and content under random sender gaps and
// receiver stalls, then a stall-free tail. Checking lives in the checker.
// ----------------------------------------------------------------------------
module testbench;
    import mf3_pkg::*;

    localparam int SB     = MF3_SAMPLE_BITS;
    localparam int S_BITS = ((SB + 7) / 8) * 8;
    localparam int M_BITS = ((SB + 29) / 8) * 8;

    // a sample that makes no result can still be in flight when the owed
    // count drops to zero, so wait for the pipe to empty
    localparam int SETTLE_CYCLES  = 2 * (MED_LATENCY + 2) + 4;
    localparam int RANDOM_SAMPLES = 100;

    // indexes past the two registers: writes there must change nothing
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_A = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_B = CFG_INDEX_BITS'(3);

    typedef enum int {FULL_RANGE, NARROW_RANGE, EXTREMES} sample_mix_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [S_BITS-1:0]         s_tdata;    // height_in
    logic                      m_tvalid;
    logic                      m_tready;
    logic [M_BITS-1:0]         m_tdata;    // filtered_value, out_row, out_col, pad
    logic                      m_tlast;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;

    logic end_of_run;
    bit   calm;          // tail of the run: no gaps, no stalls
    int   mismatch_count;
    int   cells_owed;
    int   samples_sent;

    median3x3_grid_filter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    mf3_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .end_of_run     (end_of_run),
        .mismatch_count (mismatch_count),
        .cells_owed     (cells_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop, far beyond the slowest passing run
    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    // Receiver: ready-high stretches of random length broken by stall
    // bursts of random length, so stalls land on every phase of the pipe.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge aclk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
            end
        end
    end

    // Values whose bits together cover every tdata bit both ways.
    function automatic logic [SB-1:0] extreme_sample(input int k);
        case (k % 9)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            5: return 32'h5555_5555;
            6: return 32'hAAAA_AAAA;
            7: return 32'h0001_0000;   // +1.0
            default: return 32'hFFFF_0000;   // -1.0
        endcase
    endfunction

    function automatic logic [SB-1:0] pick_sample(input sample_mix_t mix);
        case (mix)
            // tiny range: lots of ties inside a window
            NARROW_RANGE: return SB'(int'($urandom_range(0, 8)) - 4);
            EXTREMES:     return extreme_sample($urandom_range(0, 8));
            default:      return SB'($urandom);
        endcase
    endfunction

    // Called and returns on a falling edge. tvalid may be left high so
    // back-to-back beats go out without a bubble.
    task automatic push_sample(input logic [SB-1:0] v);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_BITS'($urandom);
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_BITS'(v);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        samples_sent++;
    endtask

    // Sender holds off until every owed result has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (cells_owed != 0);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_grid(input int w, input int h);
        settle();
        if ($urandom_range(0, 1) == 0) begin
            write_reg(CFG_GRID_WIDTH,  CFG_DATA_BITS'(w));
            write_reg(CFG_GRID_HEIGHT, CFG_DATA_BITS'(h));
        end else begin
            write_reg(CFG_GRID_HEIGHT, CFG_DATA_BITS'(h));
            write_reg(CFG_GRID_WIDTH,  CFG_DATA_BITS'(w));
        end
    endtask

    task automatic send_grid(input int n, input sample_mix_t mix);
        for (int i = 0; i < n; i++) begin
            // now and then hold off mid-grid until the output side is empty
            if (!calm && $urandom_range(0, 199) == 0) wait_drained();
            push_sample(pick_sample(mix));
        end
    endtask

    initial begin
        int          w, h, n, choice;
        sample_mix_t mix;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        end_of_run   = 1'b0;
        calm         = 1'b0;
        samples_sent = 0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed ----
        // Reset size is 3x3: eight borders around one interior cell. The
        // last sample closes the window, so a median and a border beat pair up.
        for (int k = 0; k < 9; k++) push_sample(extreme_sample(k));
        // grid wraps: the next samples start a fresh grid at row 0
        for (int k = 0; k < 3; k++) push_sample(extreme_sample(8 - k));
        // writes past the two registers must not restart the grid
        settle();
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '0);
        for (int k = 0; k < 3; k++) push_sample(extreme_sample(k + 3));
        // zero width and height act as 1x1
        set_grid(0, 0);
        send_grid(2, EXTREMES);
        // two columns: every cell a border; height over the limit saturates
        set_grid(2, 13'h1FFF);
        send_grid(4, EXTREMES);
        // 4x3: interior samples of row 1 complete no window, so no beat
        set_grid(4, 3);
        send_grid(6, EXTREMES);

        // ---- widest and tallest grids, few of them ----
        // width field over the limit (truncated to 11 bits, then saturated to
        // a full 1024-column row): column index reaches its top value
        set_grid(13'h1FFF, 3);
        send_grid(MF3_MAX_WIDTH + 3, FULL_RANGE);
        // one column, 4096 rows: all borders, row index climbs
        set_grid(1, HEIGHT_LIMIT);
        send_grid(40, NARROW_RANGE);

        // ---- random grids ----
        samples_sent = 0;
        while (samples_sent < RANDOM_SAMPLES) begin
            choice = $urandom_range(0, 9);
            mix    = sample_mix_t'($urandom_range(0, 2));
            if (choice < 6) begin
                // well-formed grids, sometimes two back to back
                w = $urandom_range(3, 12);
                h = $urandom_range(3, 8);
                set_grid(w, h);
                send_grid(w * h * $urandom_range(1, 2), mix);
            end else if (choice < 8) begin
                // cut short: the next register write restarts the grid
                w = $urandom_range(3, 16);
                h = $urandom_range(3, 16);
                set_grid(w, h);
                send_grid($urandom_range(1, w * h - 1), mix);
            end else if (choice == 8) begin
                // degenerate sizes, all borders
                w = $urandom_range(0, 2);
                h = $urandom_range(0, 5);
                set_grid(w, h);
                send_grid($urandom_range(1, 20), mix);
            end else begin
                // spare-index write mid-grid, then the grid carries on
                w = $urandom_range(3, 8);
                h = $urandom_range(3, 6);
                set_grid(w, h);
                n = $urandom_range(1, w * h - 1);
                send_grid(n, mix);
                settle();
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          CFG_DATA_BITS'($urandom));
                send_grid(w * h - n, mix);
            end
        end

        // ---- tail at full rate, no stalls ----
        calm = 1'b1;
        set_grid(9, 7);
        send_grid(9 * 7, FULL_RANGE);

        settle();
        end_of_run <= 1'b1;
        repeat (2) @(negedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
